// ----- src/wmv_pkg.sv -----
// shared types and constants for the windowed mean block
package wmv_pkg;

  localparam int CHANNELS_DEF  = 8;
  localparam int MAX_DEPTH_DEF = 64;
  localparam int LEN_RESET     = 64;
  localparam int CH_W          = 3;
  localparam int DATA_W        = 32;
  localparam int SLOTS_W       = 7;
  localparam int ADDR_W        = 3;

  localparam logic [ADDR_W-1:0] ADDR_WINDOW_LEN = 3'd0;

  // queued input word with its classification
  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [DATA_W-1:0] sample;
    logic              sample_valid;
    logic              ch_ok;
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

endpackage

// ----- src/wmv_front.sv -----
// input side: accepts words, flags out-of-range channels, two-entry queue
module wmv_front #(
  parameter int CHANNELS = wmv_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wmv_pkg::CH_W-1:0]    channel,
  input  logic signed [wmv_pkg::DATA_W-1:0] sample,
  input  logic                        sample_valid,
  output logic                        q_valid,
  output wmv_pkg::item_t              q_item,
  input  logic                        q_pop
);

  wmv_pkg::item_t entry [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;
  logic           push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr].channel      <= channel;
      entry[wr_ptr].sample       <= sample;
      entry[wr_ptr].sample_valid <= sample_valid;
      entry[wr_ptr].ch_ok        <= (32'(channel) < CHANNELS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- src/wmv_back.sv -----
// work side: window store, running sums and counts, serial divider, result register
module wmv_back #(
  parameter int CHANNELS  = wmv_pkg::CHANNELS_DEF,
  parameter int MAX_DEPTH = wmv_pkg::MAX_DEPTH_DEF,
  localparam int LEN_W    = $clog2(MAX_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [LEN_W-1:0]            cfg_len,
  output logic [LEN_W-1:0]            window_len,
  input  logic                        q_valid,
  input  wmv_pkg::item_t              q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wmv_pkg::CH_W-1:0]    out_channel,
  output logic                        mean_ok,
  output logic signed [wmv_pkg::DATA_W-1:0] mean_value,
  output logic                        latest_ok,
  output logic signed [wmv_pkg::DATA_W-1:0] latest_value,
  output logic [wmv_pkg::SLOTS_W-1:0] valid_slots
);

  localparam int DW        = wmv_pkg::DATA_W;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH);
  localparam int CNT_W     = LEN_W;
  localparam int SUM_W     = DW + LEN_W;
  localparam int CHI_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS * MAX_DEPTH;
  localparam int MADDR_W   = $clog2(MEM_DEPTH);
  localparam int DIVC_W    = $clog2(SUM_W + 1);
  localparam int LEN_INIT  = (wmv_pkg::LEN_RESET > MAX_DEPTH) ? MAX_DEPTH : wmv_pkg::LEN_RESET;

  wmv_pkg::state_t state;

  // per-channel state
  logic [DEPTH_W-1:0]       wp      [CHANNELS];
  logic                     wrapped [CHANNELS];
  logic signed [SUM_W-1:0]  sum     [CHANNELS];
  logic [CNT_W-1:0]         cnt     [CHANNELS];

  // window store: valid flag and sample
  logic [DW:0]              mem [MEM_DEPTH];
  logic [DW:0]              rdata;
  logic [MADDR_W-1:0]       addr;
  logic                     mem_we;
  logic [DW:0]              wdata;

  wmv_pkg::item_t           cur;
  logic [CHI_W-1:0]         chi;
  logic [CHI_W-1:0]         q_chi;
  logic [DEPTH_W-1:0]       slot;
  logic [DEPTH_W-1:0]       slot_next;
  logic [LEN_W-1:0]         slot_inc;
  logic                     wrap_now;

  logic                     old_v;
  logic signed [SUM_W-1:0]  old_s;
  logic signed [SUM_W-1:0]  new_s;
  logic signed [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]         cnt_next;

  // divider
  logic [SUM_W-1:0]         quo;
  logic [CNT_W-1:0]         rem;
  logic [CNT_W-1:0]         divisor;
  logic                     neg;
  logic [DIVC_W-1:0]        dcount;
  logic [CNT_W:0]           rem_sh;
  logic                     take;

  assign q_chi = CHI_W'(q_item.channel);
  assign q_pop = (state == wmv_pkg::ST_IDLE) && q_valid;

  always_comb begin
    slot_next = (LEN_W'(wp[q_chi]) >= window_len) ? '0 : wp[q_chi];
  end

  assign slot_inc = LEN_W'(slot) + LEN_W'(1);
  assign wrap_now = (slot_inc == window_len);

  assign old_v    = wrapped[chi] && rdata[DW];
  assign old_s    = old_v ? SUM_W'(signed'(rdata[DW-1:0])) : '0;
  assign new_s    = cur.sample_valid ? SUM_W'(signed'(cur.sample)) : '0;
  assign sum_next = sum[chi] - old_s + new_s;
  assign cnt_next = cnt[chi] - CNT_W'(old_v) + CNT_W'(cur.sample_valid);

  assign mem_we = (state == wmv_pkg::ST_UPDATE);
  assign wdata  = {cur.sample_valid, cur.sample_valid ? cur.sample : '0};

  assign rem_sh = {rem, quo[SUM_W-1]};
  assign take   = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wmv_pkg::ST_IDLE;
      out_valid  <= 1'b0;
      window_len <= LEN_W'(LEN_INIT);
      for (int i = 0; i < CHANNELS; i++) begin
        wp[i]      <= '0;
        wrapped[i] <= 1'b0;
        sum[i]     <= '0;
        cnt[i]     <= '0;
      end
    end else begin
      if (cfg_we) begin
        window_len <= cfg_len;
        for (int i = 0; i < CHANNELS; i++) begin
          wp[i]      <= '0;
          wrapped[i] <= 1'b0;
          sum[i]     <= '0;
          cnt[i]     <= '0;
        end
      end
      unique case (state)
        wmv_pkg::ST_IDLE: begin
          if (q_valid) begin
            cur  <= q_item;
            chi  <= q_chi;
            slot <= slot_next;
            addr <= MADDR_W'(32'(q_chi) * MAX_DEPTH) + MADDR_W'(slot_next);
            out_channel <= q_item.channel;
            if (!q_item.ch_ok) begin
              mean_ok      <= 1'b0;
              mean_value   <= '0;
              latest_ok    <= 1'b0;
              latest_value <= '0;
              valid_slots  <= '0;
              out_valid    <= 1'b1;
              state        <= wmv_pkg::ST_OUT;
            end else begin
              state <= wmv_pkg::ST_READ;
            end
          end
        end
        wmv_pkg::ST_READ: begin
          state <= wmv_pkg::ST_UPDATE;
        end
        wmv_pkg::ST_UPDATE: begin
          sum[chi]     <= sum_next;
          cnt[chi]     <= cnt_next;
          wp[chi]      <= wrap_now ? '0 : DEPTH_W'(slot_inc);
          if (wrap_now) wrapped[chi] <= 1'b1;
          latest_ok    <= cur.sample_valid;
          latest_value <= cur.sample_valid ? cur.sample : '0;
          valid_slots  <= wmv_pkg::SLOTS_W'(cnt_next);
          mean_ok      <= (cnt_next != '0);
          neg          <= sum_next[SUM_W-1];
          quo          <= sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
          rem          <= '0;
          divisor      <= cnt_next;
          dcount       <= DIVC_W'(SUM_W);
          if (cnt_next == '0) begin
            mean_value <= '0;
            out_valid  <= 1'b1;
            state      <= wmv_pkg::ST_OUT;
          end else begin
            state <= wmv_pkg::ST_DIV;
          end
        end
        wmv_pkg::ST_DIV: begin
          if (dcount == '0) begin
            mean_value <= neg ? -quo[DW-1:0] : quo[DW-1:0];
            out_valid  <= 1'b1;
            state      <= wmv_pkg::ST_OUT;
          end else begin
            rem    <= take ? CNT_W'(rem_sh - {1'b0, divisor}) : CNT_W'(rem_sh);
            quo    <= {quo[SUM_W-2:0], take};
            dcount <= dcount - DIVC_W'(1);
          end
        end
        wmv_pkg::ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= wmv_pkg::ST_IDLE;
          end
        end
        default: state <= wmv_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/windowed_mean_with_valid_mask.sv -----
// windowed mean with valid mask: top level
// Per-channel moving average over a circular window of Q16.16 samples, each slot
// flagged valid or missing. A word carries a channel, a sample and its valid bit;
// it overwrites the channel's oldest slot and the result word returns the mean of
// the valid slots (truncated toward zero), the newest sample and the valid slot
// count. A front queue of two words takes input while the back end works; the
// back end reads the slot, updates the sums and counts and then runs a serial divider,
// one restoring divide step per sum bit, and holds the result while out_stall is high.
// A channel beyond CHANNELS returns zeros straight from the idle state, skipping
// the divider. Writing window_len (address 0, clamped to 1..MAX_DEPTH) clears every
// window at once; no clearing pass is needed after reset or a write.
module windowed_mean_with_valid_mask #(
  parameter int CHANNELS  = wmv_pkg::CHANNELS_DEF,
  parameter int MAX_DEPTH = wmv_pkg::MAX_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // apb register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wmv_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // input words
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wmv_pkg::CH_W-1:0]          channel,
  input  logic signed [wmv_pkg::DATA_W-1:0] sample,
  input  logic                              sample_valid,
  // result words
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wmv_pkg::CH_W-1:0]          out_channel,
  output logic                              mean_ok,
  output logic signed [wmv_pkg::DATA_W-1:0] mean_value,
  output logic                              latest_ok,
  output logic signed [wmv_pkg::DATA_W-1:0] latest_value,
  output logic [wmv_pkg::SLOTS_W-1:0]       valid_slots
);

  localparam int LEN_W = $clog2(MAX_DEPTH + 1);

  logic                 cfg_we;
  logic [LEN_W-1:0]     cfg_len;
  logic [LEN_W-1:0]     window_len;
  logic [6:0]           wr_len;
  logic                 q_valid;
  logic                 q_pop;
  wmv_pkg::item_t       q_item;

  assign pready = 1'b1;
  // register write on the access phase, only at the window_len address
  assign cfg_we = psel && penable && pwrite && pready && (paddr == wmv_pkg::ADDR_WINDOW_LEN);

  // clamp written length to 1..MAX_DEPTH
  assign wr_len = pwdata[6:0];
  always_comb begin
    priority if (wr_len == 7'd0) cfg_len = LEN_W'(1);
    else if (32'(wr_len) > MAX_DEPTH) cfg_len = LEN_W'(MAX_DEPTH);
    else cfg_len = LEN_W'(wr_len);
  end

  assign prdata = (paddr == wmv_pkg::ADDR_WINDOW_LEN) ? 32'(window_len) : 32'd0;

  wmv_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .channel, .sample, .sample_valid,
    .q_valid, .q_item, .q_pop
  );

  wmv_back #(.CHANNELS(CHANNELS), .MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk, .rst, .cfg_we, .cfg_len, .window_len,
    .q_valid, .q_item, .q_pop,
    .out_valid, .out_stall, .out_channel, .mean_ok, .mean_value,
    .latest_ok, .latest_value, .valid_slots
  );

endmodule

// ----- src/wmv_checker.sv -----
// port-level checks for the windowed mean block, bound to the top level
module wmv_port_checks (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [wmv_pkg::CH_W-1:0]          out_channel,
  input logic                              mean_ok,
  input logic signed [wmv_pkg::DATA_W-1:0] mean_value,
  input logic                              latest_ok,
  input logic signed [wmv_pkg::DATA_W-1:0] latest_value,
  input logic [wmv_pkg::SLOTS_W-1:0]       valid_slots
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean_value) && $stable(out_channel))
    else $error("result word changed under stall");

  a_mean_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mean_ok |-> mean_value == '0 && valid_slots == '0)
    else $error("mean not zero without valid slots");

  a_latest_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !latest_ok |-> latest_value == '0)
    else $error("latest value not zero when missing");

  // a valid newest sample means the window holds at least one valid slot
  a_latest_mean: assert property (@(posedge clk) disable iff (rst)
    out_valid && latest_ok |-> mean_ok && valid_slots != '0)
    else $error("valid newest sample but no mean");

endmodule

bind windowed_mean_with_valid_mask wmv_port_checks u_wmv_port_checks (.*);

// ----- dv/wmv_checker.sv -----
// checker for the windowed mean block: watches the input words, the result words and the register port
`timescale 1ns / 100ps

module wmv_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wmv_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  input  logic                              pready,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [wmv_pkg::CH_W-1:0]          channel,
  input  logic signed [wmv_pkg::DATA_W-1:0] sample,
  input  logic                              sample_valid,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [wmv_pkg::CH_W-1:0]          out_channel,
  input  logic                              mean_ok,
  input  logic signed [wmv_pkg::DATA_W-1:0] mean_value,
  input  logic                              latest_ok,
  input  logic signed [wmv_pkg::DATA_W-1:0] latest_value,
  input  logic [wmv_pkg::SLOTS_W-1:0]       valid_slots,
  output int                                errors,
  output int                                pending
);
  import wmv_pkg::*;

  localparam int NCH   = CHANNELS_DEF;
  localparam int DEPTH = MAX_DEPTH_DEF;

  typedef struct {
    logic [CH_W-1:0]          ch;
    logic                     m_ok;
    logic signed [DATA_W-1:0] m_val;
    logic                     l_ok;
    logic signed [DATA_W-1:0] l_val;
    logic [SLOTS_W-1:0]       slots;
  } mean_word_t;

  mean_word_t expected_means[$];

  logic signed [DATA_W-1:0] slot_value [NCH*DEPTH];
  bit                       slot_live  [NCH*DEPTH];
  int                       wr_slot    [NCH];
  longint                   win_sum    [NCH];
  int                       win_count  [NCH];
  int                       win_len;

  assign pending = expected_means.size();

  function automatic int clamp_window(logic [31:0] v);
    int n;
    n = int'(v[6:0]);
    if (n < 1) return 1;
    if (n > DEPTH) return DEPTH;
    return n;
  endfunction

  task automatic clear_windows();
    for (int i = 0; i < NCH*DEPTH; i++) slot_live[i] = 0;
    for (int c = 0; c < NCH; c++) begin
      wr_slot[c] = 0;
      win_sum[c] = 0;
      win_count[c] = 0;
    end
  endtask

  // push one sample into its window and work out the result word
  function automatic mean_word_t push_sample(logic [CH_W-1:0] ch,
                                             logic signed [DATA_W-1:0] smp, logic v);
    mean_word_t w;
    int slot;
    int idx;
    w = '{ch: ch, m_ok: 0, m_val: '0, l_ok: 0, l_val: '0, slots: '0};
    if (int'(ch) >= NCH) return w;
    slot = wr_slot[ch];
    if (slot >= win_len) slot = 0;
    idx = int'(ch) * DEPTH + slot;
    if (slot_live[idx]) begin
      win_sum[ch] -= longint'(slot_value[idx]);
      if (win_count[ch] > 0) win_count[ch]--;
    end
    slot_value[idx] = v ? smp : '0;
    slot_live[idx] = v;
    if (v) begin
      win_sum[ch] += longint'(smp);
      win_count[ch]++;
    end
    wr_slot[ch] = (slot + 1) % win_len;
    w.m_ok = win_count[ch] != 0;
    w.m_val = w.m_ok ? DATA_W'(win_sum[ch] / longint'(win_count[ch])) : '0;
    w.l_ok = v;
    w.l_val = v ? smp : '0;
    w.slots = SLOTS_W'(win_count[ch]);
    return w;
  endfunction

  always @(posedge clk) begin
    mean_word_t got;
    mean_word_t want;
    if (rst) begin
      expected_means.delete();
      clear_windows();
      win_len = clamp_window(LEN_RESET);
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_WINDOW_LEN) begin
        win_len = clamp_window(pwdata);
        clear_windows();
      end
      if (out_valid && !out_stall) begin
        got = '{ch: out_channel, m_ok: mean_ok, m_val: mean_value, l_ok: latest_ok,
                l_val: latest_value, slots: valid_slots};
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected word ch=%0d mean=%0d/%0b latest=%0d/%0b slots=%0d",
                   $time, got.ch, got.m_val, got.m_ok, got.l_val, got.l_ok, got.slots);
          errors <= errors + 1;
        end else begin
          want = expected_means.pop_front();
          if (got.ch !== want.ch || got.m_ok !== want.m_ok || got.m_val !== want.m_val ||
              got.l_ok !== want.l_ok || got.l_val !== want.l_val ||
              got.slots !== want.slots) begin
            $display("%0t: expected ch=%0d mean=%0d/%0b latest=%0d/%0b slots=%0d", $time,
                     want.ch, want.m_val, want.m_ok, want.l_val, want.l_ok, want.slots);
            $display("%0t: actual   ch=%0d mean=%0d/%0b latest=%0d/%0b slots=%0d", $time,
                     got.ch, got.m_val, got.m_ok, got.l_val, got.l_ok, got.slots);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_means.push_back(push_sample(channel, sample, sample_valid));
    end
  end

endmodule

// ----- dv/windowed_mean_with_valid_mask_tb.sv -----
// testbench top for the windowed mean block: stimulus, register writes and verdict
`timescale 1ns / 100ps

module windowed_mean_with_valid_mask_tb;
  import wmv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;

  logic              psel = 0;
  logic              penable = 0;
  logic              pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic                     in_valid = 0;
  logic                     in_stall;
  logic [CH_W-1:0]          channel = '0;
  logic signed [DATA_W-1:0] sample = '0;
  logic                     sample_valid = 0;

  logic                     out_valid;
  logic                     out_stall = 0;
  logic [CH_W-1:0]          out_channel;
  logic                     mean_ok;
  logic signed [DATA_W-1:0] mean_value;
  logic                     latest_ok;
  logic signed [DATA_W-1:0] latest_value;
  logic [SLOTS_W-1:0]       valid_slots;

  int errors;
  int pending;
  int cycles = 0;
  bit quiet = 0;  // no idling on either side while set

  windowed_mean_with_valid_mask i_dut (.*);

  wmv_checker i_checker (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("windowed_mean_with_valid_mask: mismatch");
      $finish;
    end
  end

  // result side stalls about 30% of cycles unless quiet
  always @(posedge clk)
    out_stall <= !rst && !quiet && ($urandom_range(99) < 30);

  // one register write: setup cycle then access cycle
  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // offer one word and hold it until taken, then maybe idle a while
  task automatic send_word(logic [CH_W-1:0] ch, logic [31:0] smp, logic v);
    in_valid <= 1;
    channel <= ch;
    sample <= smp;
    sample_valid <= v;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // wait out every expected word, then let the back end settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic random_words(int n);
    for (int i = 0; i < n; i++)
      send_word(3'($urandom_range(7)), rand_sample(), $urandom_range(99) < 80);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed at reset length: extremes, missing samples, empty windows
    send_word(3'd3, 32'h1234_5678, 0);
    send_word(3'd0, 32'h7fff_ffff, 1);
    send_word(3'd0, 32'h7fff_ffff, 1);
    send_word(3'd0, 32'h8000_0000, 1);
    send_word(3'd0, 32'hffff_ffff, 0);
    send_word(3'd7, 32'hffff_ffff, 1);
    send_word(3'd7, 32'h8000_0000, 1);
    send_word(3'd5, 32'h0000_0003, 1);
    send_word(3'd5, 32'hffff_fffe, 1);
    drain();

    // short window: overwrite of valid slots, window emptied by missing samples
    reg_write(ADDR_WINDOW_LEN, 32'd2);
    send_word(3'd1, 32'd10, 1);
    send_word(3'd1, 32'd20, 1);
    send_word(3'd1, -32'sd35, 1);
    send_word(3'd1, 32'd0, 0);
    send_word(3'd1, 32'd0, 0);
    send_word(3'd1, 32'h8000_0000, 1);
    drain();

    // zero length reads as one slot
    reg_write(ADDR_WINDOW_LEN, 32'd0);
    send_word(3'd2, 32'd7, 1);
    send_word(3'd2, 32'd9, 0);
    send_word(3'd2, 32'h7fff_ffff, 1);
    random_words(50);
    drain();

    // above the limit, upper data bits set, no idling anywhere
    reg_write(ADDR_WINDOW_LEN, 32'hffff_ff7f);
    quiet = 1;
    random_words(80);
    drain();
    quiet = 0;

    // write to an address with no register: windows keep their contents
    reg_write(3'd4, 32'd3);
    random_words(40);
    drain();

    reg_write(ADDR_WINDOW_LEN, 32'hffff_ff85);
    random_words(60);
    drain();

    reg_write(ADDR_WINDOW_LEN, 32'd65);
    random_words(40);
    drain();

    reg_write(ADDR_WINDOW_LEN, 32'd1);
    random_words(40);
    drain();

    reg_write(ADDR_WINDOW_LEN, 32'($urandom_range(3, 63)));
    random_words(80);
    drain();

    if (errors == 0) begin
      $display("windowed_mean_with_valid_mask: match");
    end else begin
      $display("windowed_mean_with_valid_mask: mismatch");
    end
    $finish;
  end

endmodule
